// ----- design/tmd_pkg.sv -----
`default_nettype none

package tmd_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int MAX_SIDE   = 5;
    localparam int PIXEL_BITS = 8;
    localparam int MAX_ROWS   = 4096;
    localparam int WIN_N      = MAX_SIDE * MAX_SIDE;
    localparam int MED_IDX    = (WIN_N - 1) / 2;

    localparam int COL_W  = $clog2(MAX_LINE);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int WID_W  = COL_W + 1;
    localparam int HGT_W  = ROW_W + 1;
    localparam int SLOT_W = $clog2(MAX_SIDE);
    localparam int HALF_W = $clog2(MAX_SIDE);
    localparam int SIDE_W = 3;
    localparam int THR_W  = 16;
    localparam int PROD_W = THR_W + PIXEL_BITS;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    // one line-store column: one pixel per row slot
    typedef pix_t [MAX_SIDE-1:0] colw_t;
    typedef pix_t [WIN_N-1:0] win_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_SIDE      = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

    // per-item info carried down the pipeline
    typedef struct packed {
        pix_t             centre;
        logic [ROW_W-1:0] orow;
        logic [COL_W-1:0] ocol;
        logic             last;
    } sb_t;

endpackage

`default_nettype wire

// ----- design/tmd_ram.sv -----
`default_nettype none

module tmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read-first, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/thresholded_median_denoise_unit.sv -----
// Throughput: one pixel per cycle while no result is held at the output; the line memory
// is read and written once per pixel (one column word), and the 25-stage sorting network
// takes a new window every cycle while the pipeline advances.
// Reset: asynchronous, clears counters, pipeline valid bits and configuration to defaults
// (width 512, height 512, side 3, threshold 26); the line memory is not cleared.
`default_nettype none

module thresholded_median_denoise_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [tmd_pkg::PIXEL_BITS-1:0] pixel_in,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [tmd_pkg::PIXEL_BITS-1:0] pixel_out,
    output      logic [tmd_pkg::ROW_W-1:0]      out_row,
    output      logic [tmd_pkg::COL_W-1:0]      out_col,
    output      logic                          frame_last,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);

    localparam int NS = tmd_pkg::WIN_N;

    // configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  side_reg;
    logic [15:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd512;
            height_reg <= 13'd512;
            side_reg   <= 3'd3;
            thr_reg    <= 16'd26;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (tmd_pkg::reg_idx_t'(cfg_index))
                tmd_pkg::REG_WIDTH:     width_reg  <= cfg_data[10:0];
                tmd_pkg::REG_HEIGHT:    height_reg <= cfg_data[12:0];
                tmd_pkg::REG_SIDE:      side_reg   <= cfg_data[2:0];
                tmd_pkg::REG_THRESHOLD: thr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [tmd_pkg::WID_W-1:0]  w_eff;
    logic [tmd_pkg::HGT_W-1:0]  h_eff;
    logic [tmd_pkg::SIDE_W-1:0] side_sat;
    logic [tmd_pkg::SIDE_W-1:0] side_eff;
    logic [tmd_pkg::HALF_W-1:0] half;
    logic [tmd_pkg::SIDE_W-1:0] twoh;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = tmd_pkg::WID_W'(1);
        else if (width_reg > tmd_pkg::WID_W'(tmd_pkg::MAX_LINE))
            w_eff = tmd_pkg::WID_W'(tmd_pkg::MAX_LINE);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = tmd_pkg::HGT_W'(1);
        else if (height_reg > tmd_pkg::HGT_W'(tmd_pkg::MAX_ROWS))
            h_eff = tmd_pkg::HGT_W'(tmd_pkg::MAX_ROWS);
        else
            h_eff = height_reg;

        if (side_reg == '0)
            side_sat = tmd_pkg::SIDE_W'(1);
        else if (side_reg > tmd_pkg::SIDE_W'(tmd_pkg::MAX_SIDE))
            side_sat = tmd_pkg::SIDE_W'(tmd_pkg::MAX_SIDE);
        else
            side_sat = side_reg;

        side_eff = side_sat[0] ? side_sat : side_sat - tmd_pkg::SIDE_W'(1);
        half     = tmd_pkg::HALF_W'((side_eff - tmd_pkg::SIDE_W'(1)) >> 1);
        twoh     = tmd_pkg::SIDE_W'({half, 1'b0});
    end

    // global pipeline advance: everything moves unless the result is held
    logic out_valid_reg;
    logic adv;
    logic accept;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // raster counters
    logic [tmd_pkg::COL_W-1:0]  col_count_reg, col_count_next;
    logic [tmd_pkg::ROW_W-1:0]  row_count_reg, row_count_next;
    logic [tmd_pkg::SLOT_W-1:0] rslot_reg, rslot_next;

    logic [tmd_pkg::WID_W-1:0] c_inc;
    logic [tmd_pkg::HGT_W-1:0] r_inc;
    logic acc_store;
    logic acc_emit;
    logic acc_last;

    always_comb
    begin
        c_inc     = {1'b0, col_count_reg} + tmd_pkg::WID_W'(1);
        r_inc     = {1'b0, row_count_reg} + tmd_pkg::HGT_W'(1);
        acc_store = ({1'b0, col_count_reg} < w_eff) && ({1'b0, row_count_reg} < h_eff);
        acc_emit  = acc_store
                    && (col_count_reg >= tmd_pkg::COL_W'(twoh))
                    && (row_count_reg >= tmd_pkg::ROW_W'(twoh));
        acc_last  = ({1'b0, col_count_reg} == w_eff - tmd_pkg::WID_W'(1))
                    && ({1'b0, row_count_reg} == h_eff - tmd_pkg::HGT_W'(1));

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        rslot_next     = rslot_reg;
        if (c_inc >= w_eff)
        begin
            col_count_next = '0;
            if (r_inc >= h_eff)
            begin
                row_count_next = '0;
                rslot_next     = '0;
            end
            else
            begin
                row_count_next = tmd_pkg::ROW_W'(r_inc);
                rslot_next     = (rslot_reg == tmd_pkg::SLOT_W'(tmd_pkg::MAX_SIDE - 1))
                                 ? '0 : rslot_reg + tmd_pkg::SLOT_W'(1);
            end
        end
        else
        begin
            col_count_next = tmd_pkg::COL_W'(c_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            rslot_reg     <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            rslot_reg     <= rslot_next;
        end
    end

    // stage 1: column word read from the line memory
    logic                       s1_valid_reg;
    logic                       s1_store_reg;
    logic                       s1_emit_reg;
    tmd_pkg::pix_t              s1_pix_reg;
    logic [tmd_pkg::COL_W-1:0]  s1_col_reg;
    logic [tmd_pkg::SLOT_W-1:0] s1_slot_reg;
    logic [tmd_pkg::ROW_W-1:0]  s1_orow_reg;
    logic [tmd_pkg::COL_W-1:0]  s1_ocol_reg;
    logic                       s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_store_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s1_store_reg <= accept && acc_store;
            s1_emit_reg  <= accept && acc_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= pixel_in;
            s1_col_reg  <= col_count_reg;
            s1_slot_reg <= rslot_reg;
            s1_orow_reg <= row_count_reg - tmd_pkg::ROW_W'(half);
            s1_ocol_reg <= col_count_reg - tmd_pkg::COL_W'(half);
            s1_last_reg <= acc_last;
        end
    end

    logic [$bits(tmd_pkg::colw_t)-1:0] rd_data;
    tmd_pkg::colw_t word;
    tmd_pkg::colw_t word_mod;

    // forwarding of the last written column word (covers one-pixel rows)
    logic                      fwd_valid_reg;
    logic [tmd_pkg::COL_W-1:0] fwd_addr_reg;
    tmd_pkg::colw_t            fwd_data_reg;
    logic                      mem_we;

    assign mem_we = adv && s1_store_reg;

    tmd_ram #(
        .WIDTH($bits(tmd_pkg::colw_t)),
        .DEPTH(tmd_pkg::MAX_LINE)
    ) u_line_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(s1_col_reg),
        .wdata(word_mod),
        .re   (adv),
        .raddr(col_count_reg),
        .rdata(rd_data)
    );

    // merge the new pixel into its row slot
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_col_reg))
            word = fwd_data_reg;
        else
            word = tmd_pkg::colw_t'(rd_data);
        word_mod              = word;
        word_mod[s1_slot_reg] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (mem_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= s1_col_reg;
            fwd_data_reg <= word_mod;
        end
    end

    // window columns, newest first
    tmd_pkg::colw_t col_sh_reg [tmd_pkg::MAX_SIDE];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_sh_reg[0] <= word_mod;
            for (int k = 1; k < tmd_pkg::MAX_SIDE; k++)
            begin
                col_sh_reg[k] <= col_sh_reg[k-1];
            end
        end
    end

    // stage 2: window gather
    logic                       s2_emit_reg;
    logic [tmd_pkg::SLOT_W-1:0] s2_slot_reg;
    logic [tmd_pkg::ROW_W-1:0]  s2_orow_reg;
    logic [tmd_pkg::COL_W-1:0]  s2_ocol_reg;
    logic                       s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_emit_reg <= s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_slot_reg <= s1_slot_reg;
            s2_orow_reg <= s1_orow_reg;
            s2_ocol_reg <= s1_ocol_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    logic [tmd_pkg::SLOT_W-1:0] row_slot [tmd_pkg::MAX_SIDE];
    tmd_pkg::win_t              win;
    tmd_pkg::pix_t              centre;

    // out-of-window places are padded half with 0 and half with full scale,
    // so the median of all places equals the median of the window
    always_comb
    begin
        for (int i = 0; i < tmd_pkg::MAX_SIDE; i++)
        begin
            if (s2_slot_reg >= tmd_pkg::SLOT_W'(i))
                row_slot[i] = s2_slot_reg - tmd_pkg::SLOT_W'(i);
            else
                row_slot[i] = s2_slot_reg + tmd_pkg::SLOT_W'(tmd_pkg::MAX_SIDE - i);
        end
        for (int i = 0; i < tmd_pkg::MAX_SIDE; i++)
        begin
            for (int j = 0; j < tmd_pkg::MAX_SIDE; j++)
            begin
                if ((tmd_pkg::SIDE_W'(i) < side_eff) && (tmd_pkg::SIDE_W'(j) < side_eff))
                    win[i*tmd_pkg::MAX_SIDE + j] = col_sh_reg[j][row_slot[i]];
                else if (i > j)
                    win[i*tmd_pkg::MAX_SIDE + j] = '0;
                else if (i < j)
                    win[i*tmd_pkg::MAX_SIDE + j] = '1;
                else if ((i % 2) == 1)
                    win[i*tmd_pkg::MAX_SIDE + j] = '1;
                else
                    win[i*tmd_pkg::MAX_SIDE + j] = '0;
            end
        end
        centre = col_sh_reg[half][row_slot[half]];
    end

    // sorting network: odd-even transposition, one registered step per stage
    tmd_pkg::win_t sort_reg [NS+1];
    tmd_pkg::sb_t  sb_reg   [NS+1];
    logic [NS:0]   sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
        end
        else if (adv)
        begin
            sv_reg <= {sv_reg[NS-1:0], s2_emit_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sort_reg[0] <= win;
            sb_reg[0]   <= '{centre: centre, orow: s2_orow_reg,
                             ocol: s2_ocol_reg, last: s2_last_reg};
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_sort
        tmd_pkg::win_t step;

        always_comb
        begin
            step = sort_reg[k];
            for (int p = (k % 2); p + 1 < NS; p += 2)
            begin
                if (sort_reg[k][p] > sort_reg[k][p+1])
                begin
                    step[p]   = sort_reg[k][p+1];
                    step[p+1] = sort_reg[k][p];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sort_reg[k+1] <= step;
                sb_reg[k+1]   <= sb_reg[k];
            end
        end
    end

    // threshold stage: deviation and scaled median
    logic                       m_valid_reg;
    tmd_pkg::sb_t               m_sb_reg;
    tmd_pkg::pix_t              m_med_reg;
    tmd_pkg::pix_t              m_diff_reg;
    logic [tmd_pkg::PROD_W-1:0] m_prod_reg;
    tmd_pkg::pix_t              med;

    assign med = sort_reg[NS][tmd_pkg::MED_IDX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= sv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_sb_reg   <= sb_reg[NS];
            m_med_reg  <= med;
            m_diff_reg <= (med > sb_reg[NS].centre) ? med - sb_reg[NS].centre
                                                    : sb_reg[NS].centre - med;
            m_prod_reg <= tmd_pkg::PROD_W'(thr_reg) * tmd_pkg::PROD_W'(med);
        end
    end

    // output register
    logic                      keep;
    tmd_pkg::pix_t             pixel_out_reg;
    logic [tmd_pkg::ROW_W-1:0] out_row_reg;
    logic [tmd_pkg::COL_W-1:0] out_col_reg;
    logic                      frame_last_reg;

    assign keep = (tmd_pkg::PROD_W'({m_diff_reg, 8'd0}) <= m_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_out_reg  <= keep ? m_sb_reg.centre : m_med_reg;
            out_row_reg    <= m_sb_reg.orow;
            out_col_reg    <= m_sb_reg.ocol;
            frame_last_reg <= m_sb_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

`ifndef SYNTHESIS
    // input is held back only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // row slot stays within the line store rows
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rslot_reg <= tmd_pkg::SLOT_W'(tmd_pkg::MAX_SIDE - 1))
        else $error("row slot out of range");

    // an interior pixel is always one that gets stored
    a_emit_store: assert property (@(posedge clk) disable iff (!rst_n)
        s1_emit_reg |-> (s1_store_reg && s1_valid_reg))
        else $error("result issued for an unstored pixel");

    // a frozen pipeline keeps its result
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(out_valid_reg) && $stable(sv_reg))
        else $error("pipeline moved while frozen");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tmd_pkg::*;

    // one filtered pixel as it leaves the block
    typedef struct packed {
        pix_t             pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } px_result_t;

    // directed row: pixel, config set to load first (0 = none), typed result
    typedef struct packed {
        logic [2:0] setup;
        pix_t       pix;
        logic       typed;
        px_result_t res;
    } stim_row_t;

    localparam int DIR_N      = 17;
    localparam int DRAIN_CYC  = 40;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pix_t pixel_in;
    logic out_valid;
    logic out_stall;
    pix_t pixel_out;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic frame_last;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    thresholded_median_denoise_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
        .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
        .out_row(out_row), .out_col(out_col), .frame_last(frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // filtered pixels still owed by the block
    px_result_t pending_px[$];
    int errors;
    int n_pixels;
    int n_results;
    int n_frames;
    int n_cfg;
    int cycles;
    int send_idle;
    int recv_stall;

    // predictor state
    pix_t        rows_mem [MAX_SIDE][MAX_LINE];
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned reg_width;
    int unsigned reg_height;
    int unsigned reg_side;
    int unsigned reg_thr;

    // directed stimulus: side 1 passes pixels through; then a lone salt pixel
    stim_row_t dir_tab [DIR_N] = '{
        '{3'd1, 8'h00, 1'b1, '{8'h00, 12'd0, 10'd0, 1'b0}},
        '{3'd0, 8'hFF, 1'b1, '{8'hFF, 12'd0, 10'd1, 1'b0}},
        '{3'd0, 8'h55, 1'b1, '{8'h55, 12'd0, 10'd2, 1'b0}},
        '{3'd0, 8'hAA, 1'b1, '{8'hAA, 12'd0, 10'd3, 1'b0}},
        '{3'd0, 8'h01, 1'b1, '{8'h01, 12'd1, 10'd0, 1'b0}},
        '{3'd0, 8'h80, 1'b1, '{8'h80, 12'd1, 10'd1, 1'b0}},
        '{3'd0, 8'hFE, 1'b1, '{8'hFE, 12'd1, 10'd2, 1'b0}},
        '{3'd0, 8'h7F, 1'b1, '{8'h7F, 12'd1, 10'd3, 1'b1}},
        '{3'd2, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'hFF, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b0, '0},
        '{3'd0, 8'h00, 1'b1, '{8'h00, 12'd1, 10'd1, 1'b1}}
    };

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results owed", cycles, pending_px.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // effective register values, after clamping
    function automatic int unsigned eff_w();
        if (reg_width == 0) return 1;
        if (reg_width > MAX_LINE) return MAX_LINE;
        return reg_width;
    endfunction

    function automatic int unsigned eff_h();
        if (reg_height == 0) return 1;
        if (reg_height > MAX_ROWS) return MAX_ROWS;
        return reg_height;
    endfunction

    function automatic int unsigned eff_side();
        int unsigned s;
        s = reg_side;
        if (s == 0) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        if (s[0] == 1'b0) s = s - 1;
        return s;
    endfunction

    // advance the filter by one pixel; returns 1 when a centre pixel is produced
    function automatic bit denoise_pixel(input pix_t p, output px_result_t res);
        int unsigned w, h, side, half, c, r, cnt, k, v, med, ctr, diff;
        int unsigned win [WIN_N];
        bit hit;
        w = eff_w();
        h = eff_h();
        side = eff_side();
        half = (side - 1) / 2;
        c = cur_col;
        r = cur_row;
        hit = 1'b0;
        res = '0;
        if (c < w && r < h)
        begin
            rows_mem[r % MAX_SIDE][c] = p;
            if (c >= 2 * half && r >= 2 * half)
            begin
                cnt = 0;
                for (int i = 0; i < side; i++)
                begin
                    for (int j = 0; j < side; j++)
                    begin
                        v = rows_mem[(r - 2 * half + i) % MAX_SIDE][c - 2 * half + j];
                        k = cnt;
                        while (k > 0 && win[k - 1] > v)
                        begin
                            win[k] = win[k - 1];
                            k--;
                        end
                        win[k] = v;
                        cnt++;
                    end
                end
                med = win[(cnt - 1) / 2];
                ctr = rows_mem[(r - half) % MAX_SIDE][c - half];
                diff = (med > ctr) ? med - ctr : ctr - med;
                res.pix = (diff * 256 <= reg_thr * med) ? pix_t'(ctr) : pix_t'(med);
                res.row = ROW_W'(r - half);
                res.col = COL_W'(c - half);
                res.last = (c == w - 1 && r == h - 1);
                hit = 1'b1;
            end
        end
        if (c + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            cur_col = c + 1;
        return hit;
    endfunction

    // receiver: check each result transfer, then pick the next stall
    always @(posedge clk)
    begin
        px_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_px.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result pix %h row %0d col %0d last %b",
                         $time, pixel_out, out_row, out_col, frame_last);
            end
            else
            begin
                want = pending_px.pop_front();
                if (pixel_out !== want.pix)
                begin
                    errors++;
                    $display("%0t pixel_out exp %h got %h", $time, want.pix, pixel_out);
                end
                if (out_row !== want.row)
                begin
                    errors++;
                    $display("%0t out_row exp %0d got %0d", $time, want.row, out_row);
                end
                if (out_col !== want.col)
                begin
                    errors++;
                    $display("%0t out_col exp %0d got %0d", $time, want.col, out_col);
                end
                if (frame_last !== want.last)
                begin
                    errors++;
                    $display("%0t frame_last exp %b got %b", $time, want.last, frame_last);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    // stop sending, wait until all owed results are out, then let the pipe flush
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned val);
        logic [15:0] word;
        word = 16'($urandom);
        case (idx)
            REG_WIDTH:  word[10:0] = val[10:0];
            REG_HEIGHT: word[12:0] = val[12:0];
            REG_SIDE:   word[2:0]  = val[2:0];
            default:    word       = val[15:0];
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_WIDTH:     reg_width  = word[10:0];
            REG_HEIGHT:    reg_height = word[12:0];
            REG_SIDE:      reg_side   = word[2:0];
            REG_THRESHOLD: reg_thr    = word;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic setup_frame(input int unsigned w, input int unsigned h,
                               input int unsigned s, input int unsigned t);
        wait_drained();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_SIDE, s);
        write_reg(REG_THRESHOLD, t);
    endtask

    // one pixel transfer; a typed result overrides the predicted one
    task automatic send_pixel(input pix_t p, input bit typed, input px_result_t typed_res);
        px_result_t res;
        bit hit;
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (in_stall);
        hit = denoise_pixel(p, res);
        if (typed)
            pending_px.push_back(typed_res);
        else if (hit)
            pending_px.push_back(res);
        n_pixels++;
    endtask

    function automatic pix_t noisy_pixel(input int unsigned base);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12) return 8'h00;
        if (pick < 24) return 8'hFF;
        if (pick < 34) return pix_t'($urandom);
        return pix_t'(base + $urandom_range(8) > 255 ? 255 : base + $urandom_range(8));
    endfunction

    // stream pixels until the predictor sits at the start of a frame
    task automatic finish_frame(input int unsigned base);
        do
            send_pixel(noisy_pixel(base), 1'b0, '0);
        while (cur_col != 0 || cur_row != 0);
        n_frames++;
    endtask

    task automatic pick_idling(input int unsigned mode);
        case (mode % 5)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 75; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 75; end
            3: begin send_idle = 33; recv_stall = 33; end
            default: begin send_idle = 10; recv_stall = 10; end
        endcase
    endtask

    function automatic int unsigned rand_thr();
        case ($urandom_range(4))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 64);
            3: return $urandom_range(0, 512);
            default: return $urandom & 16'hFFFF;
        endcase
    endfunction

    initial
    begin
        int unsigned w, h, s, base, frame_idx;
        in_valid  = 1'b0;
        pixel_in  = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = '0;
        errors = 0;
        n_pixels = 0;
        n_results = 0;
        n_frames = 0;
        n_cfg = 0;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        cur_col = 0;
        cur_row = 0;
        reg_width = 512;
        reg_height = 512;
        reg_side = 3;
        reg_thr = 26;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_tab[i])
        begin
            case (dir_tab[i].setup)
                3'd1: setup_frame(4, 2, 1, 0);
                3'd2: setup_frame(3, 3, 3, 0);
                default: ;
            endcase
            send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].res);
        end

        // extremes: widest line, oversized height cut short, even and oversized sides,
        // zero sizes
        pick_idling(0);
        setup_frame(2047, 1, 1, 65535);
        finish_frame(100);
        pick_idling(3);
        setup_frame(1, 8191, 1, 0);
        repeat (100) send_pixel(noisy_pixel(30), 1'b0, '0);
        wait_drained();
        write_reg(REG_HEIGHT, 2);
        finish_frame(30);
        pick_idling(2);
        setup_frame(0, 0, 0, 26);
        finish_frame(0);
        pick_idling(1);
        setup_frame(12, 9, 7, 300);
        finish_frame(200);
        setup_frame(10, 8, 6, 26);
        finish_frame(60);
        setup_frame(4, 3, 5, 26);
        finish_frame(60);

        // config shrink in the middle of a frame: columns and rows past the limits
        pick_idling(4);
        setup_frame(20, 10, 3, 40);
        repeat (47) send_pixel(noisy_pixel(120), 1'b0, '0);
        wait_drained();
        write_reg(REG_WIDTH, 5);
        repeat (13) send_pixel(noisy_pixel(120), 1'b0, '0);
        wait_drained();
        write_reg(REG_HEIGHT, 2);
        finish_frame(120);

        // random frames, mostly small
        frame_idx = 0;
        while (n_pixels < 1700)
        begin
            pick_idling(frame_idx);
            w = ($urandom_range(19) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 24);
            h = ($urandom_range(19) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 12);
            if (w > 32 && h > 4) h = 4;
            s = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : 3 + 2 * $urandom_range(1);
            setup_frame(w, h, s, rand_thr());
            base = $urandom_range(255);
            finish_frame(base);
            frame_idx++;
        end

        wait_drained();
        $display("%0d pixels in %0d frames, %0d filtered results, %0d register writes",
                 n_pixels, n_frames, n_results, n_cfg);
        $display("window sides 0..7, widths up to the 1024 clamp, counters past shrunk limits, %0d errors",
                 errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
